// ===== design/esc_pkg.sv =====
// esc_pkg: widths, constants and reciprocal multipliers for the epoch seconds
// to calendar converter. No dependencies.
`timescale 1ns / 1ps
package esc_pkg;

  localparam int EPOCH_W  = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  localparam int DAYS_W   = 16;   // whole days, up to 49710
  localparam int TOD_W    = 17;   // second of the day, below 86400
  localparam int CYC_W    = 6;    // four-year cycles, up to 34
  localparam int REM_W    = 11;   // day within a four-year period, below 1461
  localparam int YDAY_W   = 9;    // day of the year, 1 to 366
  localparam int SIH_W    = 12;   // second within the hour, below 3600

  localparam int EPOCH_YEAR     = 1970;
  localparam int SECS_PER_MIN   = 60;
  localparam int SECS_PER_HOUR  = 3600;
  localparam int SECS_PER_DAY   = 86400;
  localparam int DAYS_PER_CYCLE = 1461;

  // t / 86400 = (t >> 7) / 675; exact reciprocals, q = (x * M) >> K
  localparam int DAY_SHIFT = 7;
  localparam int DAY_DIV   = SECS_PER_DAY / (2 ** DAY_SHIFT);
  localparam int DAY_K     = 35;
  localparam longint DAY_M = ((64'd1 << DAY_K) + DAY_DIV - 1) / DAY_DIV;
  localparam int DAY_M_W   = 26;

  localparam int CYC_K     = 27;
  localparam longint CYC_M = ((64'd1 << CYC_K) + DAYS_PER_CYCLE - 1) / DAYS_PER_CYCLE;
  localparam int CYC_M_W   = 17;

  localparam int HOUR_K     = 29;
  localparam longint HOUR_M = ((64'd1 << HOUR_K) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;
  localparam int HOUR_M_W   = 18;

  localparam int MIN_K     = 18;
  localparam longint MIN_M = ((64'd1 << MIN_K) + SECS_PER_MIN - 1) / SECS_PER_MIN;
  localparam int MIN_M_W   = 13;

  // last day of each month in a common year, running total of
  // {31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31}
  localparam logic [YDAY_W-1:0] MONTH_END [0:11] = '{
    9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

endpackage

// ===== design/epoch_seconds_to_calendar_top.sv =====
// epoch_seconds_to_calendar_top: seconds since 1970-01-01 UTC to calendar
// date and time of day, seven-stage pipeline. Depends on esc_pkg.
//
//  channel  | ports                                    | handshake
//  ---------+------------------------------------------+---------------------------
//  request  | start, busy, epoch_seconds               | taken when start & !busy
//  result   | strobe, year, month, day_of_month,       | one cycle, no back-pressure
//           | hour, minute, second                     |
//
// One request per cycle; busy stays low. The pipeline depth is set by the
// chain of constant-reciprocal multiplies (days, cycles, hours, minutes)
// with a register after each. Synchronous reset empties the pipeline;
// requests in flight are dropped. The receiver cannot stall, so results
// leave in request order.
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_top
  import esc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [EPOCH_W-1:0]  epoch_seconds,
  output logic                strobe,
  output logic [YEAR_W-1:0]   year,
  output logic [MONTH_W-1:0]  month,
  output logic [DAY_W-1:0]    day_of_month,
  output logic [HOUR_W-1:0]   hour,
  output logic [MINUTE_W-1:0] minute,
  output logic [SECOND_W-1:0] second
);

  localparam int LATENCY = 7;

  logic accept;
  logic v0, v1, v2, v3, v4, v5;

  logic [EPOCH_W-1:0]  t0;
  logic [TOD_W-1:0]    t1;
  logic [DAYS_W-1:0]   days1, days2;
  logic [TOD_W-1:0]    tod2, tod3;
  logic [CYC_W-1:0]    cyc2, cyc3;
  logic [REM_W-1:0]    rem3;
  logic [HOUR_W-1:0]   hour3, hour4, hour5;
  logic [YEAR_W-1:0]   year4, year5;
  logic                leap4;
  logic [YDAY_W-1:0]   yday4;
  logic [SIH_W-1:0]    sih4, sih5;
  logic [MONTH_W-1:0]  month5;
  logic [DAY_W-1:0]    day5;
  logic [MINUTE_W-1:0] minute5;

  // combinational values per stage
  logic [EPOCH_W-DAY_SHIFT+DAY_M_W-1:0] day_prod;
  logic [DAYS_W-1:0]                    days_next;
  logic [DAYS_W+CYC_M_W-1:0]            cyc_prod;
  logic [CYC_W-1:0]                     cyc_next;
  logic [TOD_W-1:0]                     tod_next;
  logic [REM_W-1:0]                     rem_next;
  logic [TOD_W+HOUR_M_W-1:0]            hour_prod;
  logic [HOUR_W-1:0]                    hour_next;
  logic [SIH_W-1:0]                     sih_next;
  logic [1:0]                           yr_in_cyc;
  logic [YDAY_W-1:0]                    yday_next;
  logic [YEAR_W-1:0]                    year_next;
  logic [SIH_W+MIN_M_W-1:0]             min_prod;
  logic [MINUTE_W-1:0]                  minute_next;
  logic [MONTH_W-1:0]                   month_next;
  logic [DAY_W-1:0]                     day_next;
  logic [SECOND_W-1:0]                  second_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: whole days
  assign day_prod  = t0[EPOCH_W-1:DAY_SHIFT] * DAY_M_W'(DAY_M);
  assign days_next = DAYS_W'(day_prod >> DAY_K);

  // stage 2: second of day, four-year cycles
  assign tod_next = t1 - TOD_W'(days1 * TOD_W'(SECS_PER_DAY));
  assign cyc_prod = days1 * CYC_M_W'(CYC_M);
  assign cyc_next = CYC_W'(cyc_prod >> CYC_K);

  // stage 3: day within cycle, hour
  assign rem_next  = REM_W'(days2) - REM_W'(cyc2 * REM_W'(DAYS_PER_CYCLE));
  assign hour_prod = tod2 * HOUR_M_W'(HOUR_M);
  assign hour_next = HOUR_W'(hour_prod >> HOUR_K);

  // stage 4: second within hour, year and day of year
  assign sih_next = SIH_W'(tod3) - SIH_W'(hour3 * SIH_W'(SECS_PER_HOUR));

  always_comb begin
    if (rem3 < REM_W'(365)) begin
      yr_in_cyc = 2'd0;
      yday_next = YDAY_W'(rem3 + REM_W'(1));
    end else if (rem3 < REM_W'(730)) begin
      yr_in_cyc = 2'd1;
      yday_next = YDAY_W'(rem3 - REM_W'(364));
    end else if (rem3 < REM_W'(1096)) begin
      yr_in_cyc = 2'd2;
      yday_next = YDAY_W'(rem3 - REM_W'(729));
    end else begin
      yr_in_cyc = 2'd3;
      yday_next = YDAY_W'(rem3 - REM_W'(1095));
    end
  end

  assign year_next = YEAR_W'(EPOCH_YEAR) + YEAR_W'({cyc3, 2'b00}) + YEAR_W'(yr_in_cyc);

  // stage 5: minute, month and day
  assign min_prod    = sih4 * MIN_M_W'(MIN_M);
  assign minute_next = MINUTE_W'(min_prod >> MIN_K);

  always_comb begin
    logic [YDAY_W-1:0] mend;
    logic [YDAY_W-1:0] base;
    month_next = MONTH_W'(1);
    base       = '0;
    for (int i = 0; i < 11; i++) begin
      mend = MONTH_END[i] + ((i >= 1) ? YDAY_W'(leap4) : YDAY_W'(0));
      if (yday4 > mend) begin
        month_next = MONTH_W'(i + 2);
        base       = mend;
      end
    end
    day_next = DAY_W'(yday4 - base);
  end

  // stage 6: second
  assign second_next = SECOND_W'(sih5 - SIH_W'(minute5 * SIH_W'(SECS_PER_MIN)));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
      v5     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      v0     <= accept;
      v1     <= v0;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      v5     <= v4;
      strobe <= v5;
    end
  end

  always_ff @(posedge clk) begin
    t0 <= epoch_seconds;

    t1    <= t0[TOD_W-1:0];
    days1 <= days_next;

    days2 <= days1;
    tod2  <= tod_next;
    cyc2  <= cyc_next;

    cyc3  <= cyc2;
    rem3  <= rem_next;
    tod3  <= tod2;
    hour3 <= hour_next;

    year4 <= year_next;
    leap4 <= (yr_in_cyc == 2'd2);
    yday4 <= yday_next;
    hour4 <= hour3;
    sih4  <= sih_next;

    year5   <= year4;
    month5  <= month_next;
    day5    <= day_next;
    hour5   <= hour4;
    minute5 <= minute_next;
    sih5    <= sih4;

    year         <= year5;
    month        <= month5;
    day_of_month <= day5;
    hour         <= hour5;
    minute       <= minute5;
    second       <= second_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY strobe)
    else $error("request did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept, LATENCY))
    else $error("result without a matching request");

  a_yday_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (yday4 != '0) && (yday4 <= YDAY_W'(366)) && (leap4 || yday4 <= YDAY_W'(365)))
    else $error("day of year out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (month != '0) && (month <= MONTH_W'(12)) && (day_of_month != '0))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (hour <= HOUR_W'(23)) && (minute <= MINUTE_W'(59))
               && (second <= SECOND_W'(59)))
    else $error("time of day out of range");

endmodule
